/* sv/fkcg_pkg.sv */
// ----------------------------------------------------------------------------
// fkcg_pkg: shared types and constants
// Command codes, register indexes, sequencer states and cell control bundle
// for the filtered k-combination generator.
// ----------------------------------------------------------------------------
package fkcg_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int MAX_SUBSET_DEF   = 6;

  localparam int DATA_W      = 32;
  localparam int K_W         = 3;
  localparam int CMD_W       = 2;
  localparam int NUM_OUT     = 6;   // element slots in a result
  localparam int IN_TDATA_W  = 40;  // command + value, padded to bytes
  localparam int OUT_TDATA_W = 200; // six elements + found, padded to bytes
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_REQUEST = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBSET_SIZE = 2'd0,
    REG_REQUIRED    = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_WAIT,
    ST_CHECK,
    ST_STEP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_pos;    // take a new index this cycle
    logic start_zero;  // new index is 0 (first subset)
    logic self_step;   // new index is own index + 1 (pivot cell)
    logic load_val;    // capture element read from the store
  } cell_ctrl_t;

endpackage

/* sv/fkcg_ram.sv */
// ----------------------------------------------------------------------------
// fkcg_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fkcg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/fkcg_cell.sv */
// ----------------------------------------------------------------------------
// fkcg_cell: one position of the current combination
// Holds a store index and the element at that index. A new index comes from
// zero, from its own index plus one, or from the left neighbor plus one.
// ----------------------------------------------------------------------------
module fkcg_cell #(
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  fkcg_pkg::cell_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]            prev_pos,
  input  logic [fkcg_pkg::DATA_W-1:0] rd_data,
  input  logic [CNT_W-1:0]            count,
  input  logic [fkcg_pkg::K_W-1:0]    k,
  input  logic [fkcg_pkg::DATA_W-1:0] required,
  output logic [IDX_W-1:0]            pos,
  output logic [IDX_W-1:0]            pos_nxt,
  output logic [fkcg_pkg::DATA_W-1:0] val,
  output logic                        can_step,
  output logic                        hit
);

  logic [IDX_W-1:0]            pos_r;
  logic [fkcg_pkg::DATA_W-1:0] val_r;
  logic [CNT_W-1:0]            limit;

  always_comb begin
    pos_nxt = pos_r;
    if (ctrl.load_pos) begin
      if (ctrl.start_zero) begin
        pos_nxt = '0;
      end else if (ctrl.self_step) begin
        pos_nxt = pos_r + IDX_W'(1);
      end else begin
        pos_nxt = prev_pos + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (ctrl.load_val) begin
      val_r <= rd_data;
    end
  end

  // highest index this position may take: count - k + cell
  assign limit    = count - CNT_W'(k) + CNT_W'(CELL_IDX);
  assign can_step = CNT_W'(pos_r) < limit;
  assign hit      = (val_r == required);
  assign pos      = pos_r;
  assign val      = val_r;

endmodule

/* sv/filtered_k_combination_generator.sv */
// ----------------------------------------------------------------------------
// filtered_k_combination_generator: k-subset enumerator with value filter
// Loads elements into a store, then steps through k-subsets on request.
// ----------------------------------------------------------------------------
// Input stream (in_*): each request carries a command and a value. Clear and
// append give no result. A request gives one result on the output stream:
// six element slots and a found flag.
// Config channel (cfg_*): index 0 is k, index 1 the required value (0 = no
// filter). Any write of a known register, a clear and an append rewind the
// enumeration. cfg_ready is always high; write only while the block is idle.
// A request on an exhausted enumeration goes straight to emitting its result.
// The first subset fills cells 0 to k - 1; each later candidate refills the
// cells from the stepping cell p up to k - 1 from the element RAM, one read
// per cycle; skipped candidates add up, so the time a request takes depends
// on the data.
// One request is worked on at a time; in_tready is high only when idle. The
// result register holds while out_tready is low, and the next request may be
// accepted and worked on meanwhile; it waits only to hand over its result.
// Reset empties the store, sets k to 2 and turns the filter off.
// ----------------------------------------------------------------------------
module filtered_k_combination_generator #(
  parameter int MAX_ELEMENTS = fkcg_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_SUBSET   = fkcg_pkg::MAX_SUBSET_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [1:0] command, [33:2] value, [39:34] zero
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fkcg_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [31:0] elem_a, [63:32] elem_b, [95:64] elem_c,
  //            [127:96] elem_d, [159:128] elem_e, [191:160] elem_f,
  //            [192] found, [199:193] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fkcg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fkcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fkcg_pkg::DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CW    = $clog2(MAX_SUBSET);
  localparam int DW    = fkcg_pkg::DATA_W;
  localparam int KW    = fkcg_pkg::K_W;

  fkcg_pkg::state_t state_r, state_nxt;

  logic [KW-1:0]    k_r, k_nxt;
  logic [DW-1:0]    req_r, req_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             started_r, started_nxt;
  logic             done_r, done_nxt;
  logic [KW-1:0]    cur_r, cur_nxt;
  logic             first_r, first_nxt;
  logic             zero_r, zero_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [CW-1:0]    rd_cell_r, rd_cell_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [DW-1:0]    out_elem_r [fkcg_pkg::NUM_OUT];
  logic             out_load;

  fkcg_pkg::cmd_t   cmd;
  logic [DW-1:0]    in_value;
  logic             in_fire;
  logic             cfg_fire;

  logic             ram_we;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [DW-1:0]    ram_rd_data;

  fkcg_pkg::cell_ctrl_t ctrl_w [MAX_SUBSET];
  logic [IDX_W-1:0] pos_w     [MAX_SUBSET];
  logic [IDX_W-1:0] pos_nxt_w [MAX_SUBSET];
  logic [DW-1:0]    val_w     [MAX_SUBSET];
  logic [MAX_SUBSET-1:0] can_w;
  logic [MAX_SUBSET-1:0] hit_w;
  logic [MAX_SUBSET-1:0] kmask;
  logic [DW-1:0]    slot_w    [fkcg_pkg::NUM_OUT];

  logic             match;
  logic             pivot_ok;
  logic [CW-1:0]    pivot;
  logic             bad_k;

  assign cmd       = fkcg_pkg::cmd_t'(in_tdata[fkcg_pkg::CMD_W-1:0]);
  assign in_value  = in_tdata[fkcg_pkg::CMD_W +: DW];
  assign in_tready = (state_r == fkcg_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign ram_we = in_fire && (cmd == fkcg_pkg::CMD_APPEND) &&
                  (count_r < CNT_W'(MAX_ELEMENTS));

  fkcg_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (in_value),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // cell control: the cell under the fill pointer takes a new index,
  // the cell whose read was issued last cycle takes its element
  always_comb begin
    for (int i = 0; i < MAX_SUBSET; i++) begin
      ctrl_w[i] = '0;
      kmask[i]  = (KW'(i) < k_r);
      if ((state_r == fkcg_pkg::ST_FILL) && (cur_r[CW-1:0] == CW'(i))) begin
        ctrl_w[i].load_pos   = 1'b1;
        ctrl_w[i].start_zero = first_r && zero_r;
        ctrl_w[i].self_step  = first_r && !zero_r;
      end
      if (rd_pend_r && (rd_cell_r == CW'(i))) begin
        ctrl_w[i].load_val = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < MAX_SUBSET; g++) begin : g_cell
    logic [IDX_W-1:0] prev;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = pos_w[g-1];
    end

    fkcg_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl_w[g]),
      .prev_pos (prev),
      .rd_data  (ram_rd_data),
      .count    (count_r),
      .k        (k_r),
      .required (req_r),
      .pos      (pos_w[g]),
      .pos_nxt  (pos_nxt_w[g]),
      .val      (val_w[g]),
      .can_step (can_w[g]),
      .hit      (hit_w[g])
    );
  end

  assign ram_rd_addr = pos_nxt_w[cur_r[CW-1:0]];

  assign match = (req_r == '0) || (|(hit_w & kmask));

  // rightmost cell below k that can still move
  always_comb begin
    pivot_ok = 1'b0;
    pivot    = '0;
    for (int i = 0; i < MAX_SUBSET; i++) begin
      if (kmask[i] && can_w[i]) begin
        pivot_ok = 1'b1;
        pivot    = CW'(i);
      end
    end
  end

  assign bad_k = (k_r < KW'(2)) || (k_r > KW'(MAX_SUBSET)) ||
                 (CNT_W'(k_r) > count_r);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    started_nxt   = started_r;
    done_nxt      = done_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    zero_nxt      = zero_r;
    rd_pend_nxt   = 1'b0;
    rd_cell_nxt   = rd_cell_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_load      = 1'b0;

    if (cfg_fire) begin
      unique case (cfg_index)
        fkcg_pkg::REG_SUBSET_SIZE: begin
          k_nxt       = cfg_data[KW-1:0];
          started_nxt = 1'b0;
          done_nxt    = 1'b0;
        end
        fkcg_pkg::REG_REQUIRED: begin
          req_nxt     = cfg_data;
          started_nxt = 1'b0;
          done_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      fkcg_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            fkcg_pkg::CMD_CLEAR: begin
              count_nxt   = '0;
              started_nxt = 1'b0;
              done_nxt    = 1'b0;
            end
            fkcg_pkg::CMD_APPEND: begin
              if (ram_we) begin
                count_nxt = count_r + CNT_W'(1);
              end
              started_nxt = 1'b0;
              done_nxt    = 1'b0;
            end
            fkcg_pkg::CMD_REQUEST: begin
              if (done_r) begin
                found_nxt = 1'b0;
                state_nxt = fkcg_pkg::ST_EMIT;
              end else if (bad_k) begin
                done_nxt  = 1'b1;
                found_nxt = 1'b0;
                state_nxt = fkcg_pkg::ST_EMIT;
              end else if (!started_r) begin
                started_nxt = 1'b1;
                cur_nxt     = '0;
                first_nxt   = 1'b1;
                zero_nxt    = 1'b1;
                state_nxt   = fkcg_pkg::ST_FILL;
              end else begin
                state_nxt = fkcg_pkg::ST_STEP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      fkcg_pkg::ST_FILL: begin
        rd_pend_nxt = 1'b1;
        rd_cell_nxt = cur_r[CW-1:0];
        first_nxt   = 1'b0;
        if (cur_r + KW'(1) == k_r) begin
          state_nxt = fkcg_pkg::ST_WAIT;
        end else begin
          cur_nxt = cur_r + KW'(1);
        end
      end

      fkcg_pkg::ST_WAIT: begin
        state_nxt = fkcg_pkg::ST_CHECK;
      end

      fkcg_pkg::ST_CHECK: begin
        if (match) begin
          found_nxt = 1'b1;
          state_nxt = fkcg_pkg::ST_EMIT;
        end else begin
          state_nxt = fkcg_pkg::ST_STEP;
        end
      end

      fkcg_pkg::ST_STEP: begin
        if (pivot_ok) begin
          cur_nxt   = KW'(pivot);
          first_nxt = 1'b1;
          zero_nxt  = 1'b0;
          state_nxt = fkcg_pkg::ST_FILL;
        end else begin
          done_nxt  = 1'b1;
          found_nxt = 1'b0;
          state_nxt = fkcg_pkg::ST_EMIT;
        end
      end

      fkcg_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          state_nxt     = fkcg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fkcg_pkg::ST_IDLE;
      end
    endcase
  end

  for (genvar j = 0; j < fkcg_pkg::NUM_OUT; j++) begin : g_slot
    if (j < MAX_SUBSET) begin : g_used
      assign slot_w[j] = (found_r && kmask[j]) ? val_w[j] : '0;
    end else begin : g_unused
      assign slot_w[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fkcg_pkg::ST_IDLE;
      k_r         <= KW'(2);
      req_r       <= '0;
      count_r     <= '0;
      started_r   <= 1'b0;
      done_r      <= 1'b0;
      cur_r       <= '0;
      first_r     <= 1'b0;
      zero_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      rd_cell_r   <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      req_r       <= req_nxt;
      count_r     <= count_nxt;
      started_r   <= started_nxt;
      done_r      <= done_nxt;
      cur_r       <= cur_nxt;
      first_r     <= first_nxt;
      zero_r      <= zero_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_cell_r   <= rd_cell_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int j = 0; j < fkcg_pkg::NUM_OUT; j++) begin
        out_elem_r[j] <= slot_w[j];
      end
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata = '0;
    for (int j = 0; j < fkcg_pkg::NUM_OUT; j++) begin
      out_tdata[j*DW +: DW] = out_elem_r[j];
    end
    out_tdata[fkcg_pkg::NUM_OUT*DW] = out_found_r;
  end

endmodule
